### design/bhpq_pkg.sv
// Shared types and constants for the binary heap priority queue.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package bhpq_pkg;

  // Heap sizing.
  localparam int CAPACITY = 64;
  localparam int POS_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CHILD_W  = POS_W + 1;
  localparam int KEY_W    = 32;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CHILD_W-1:0]      child_t;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CHANGE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_ROOT,
    S_RM_LAST,
    S_CHG,
    S_UP,
    S_DN_L,
    S_DN_R,
    S_PLACE
  } state_t;

  typedef struct packed {
    kind_t kind;
    key_t  item_value;
    pos_t  position;
  } in_beat_t;

  typedef struct packed {
    key_t    removed_value;
    status_t status;
    pos_t    entry_total;
  } out_beat_t;

endpackage

### design/bhpq_key_ram.sv
// Key storage of the heap: one write port and one registered read port.
// Depends on bhpq_pkg for the key and address types.
`timescale 1ns / 1ps

module bhpq_key_ram (
  input  logic           clk,
  input  logic           we,
  input  bhpq_pkg::addr_t waddr,
  input  bhpq_pkg::key_t  wdata,
  input  bhpq_pkg::addr_t raddr,
  output bhpq_pkg::key_t  rdata
);
  import bhpq_pkg::*;

  key_t mem [CAPACITY];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data appears the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/bhpq_rank_unit.sv
// Shared rank comparator: tells whether the upper key must sink below the lower.
// Depends on bhpq_pkg for the key type.
`timescale 1ns / 1ps

module bhpq_rank_unit (
  input  logic           max_order,
  input  bhpq_pkg::key_t upper,
  input  bhpq_pkg::key_t lower,
  output logic           outranked
);
  import bhpq_pkg::*;

  // Strict signed compare in the direction the order register selects.
  always_comb begin
    if (max_order) begin
      outranked = (upper < lower);
    end else begin
      outranked = (lower < upper);
    end
  end

endmodule

### design/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: sequencer, count and result register.
// Depends on bhpq_pkg, bhpq_key_ram and bhpq_rank_unit.
`timescale 1ns / 1ps
//
// Channel   Ports                         Handshake
// input     in_data                       taken when start is high and busy is low
// result    out_valid, out_data           one-cycle strobe, no back-pressure
// config    cfg_we, cfg_wdata             written on any edge with cfg_we high
//
// Each beat gives one result, strobed in the cycle after the sequencer finishes.
// Insert sifts up one level at a time; remove and priority change may sift
// down, and each sift-down level costs up to two reads of the single key RAM
// port, one per child, each checked by the one shared rank comparator.
// Reset empties the heap and selects max order; the receiver cannot stall, and
// busy is high while a beat works.

module binary_heap_priority_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bhpq_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output bhpq_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import bhpq_pkg::*;

  state_t    state_r, state_nxt;
  pos_t      count_r, count_nxt;
  pos_t      p_r, p_nxt;
  key_t      cur_r, cur_nxt;
  key_t      pick_key_r, pick_key_nxt;
  logic      pick_left_r, pick_left_nxt;
  key_t      removed_r, removed_nxt;
  logic      max_order_r;
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;

  // RAM and comparator hookup.
  logic  ram_we;
  addr_t ram_waddr;
  key_t  ram_wdata;
  addr_t ram_raddr;
  key_t  ram_rdata;
  key_t  cmp_upper;
  key_t  cmp_lower;
  logic  outr;

  // Sequencer scratch.
  logic    fin_en;
  status_t fin_status;
  key_t    fin_removed;
  logic    desc_en;
  pos_t    desc_pos;
  key_t    desc_key;
  pos_t    ins_pos;
  pos_t    par_pos;
  child_t  left_pos;
  child_t  right_pos;
  child_t  count_ext;

  // Address of a 1-based position.
  function automatic addr_t addr_of(input pos_t pos);
    pos_t dec;
    dec = pos - pos_t'(1);
    return dec[ADDR_W-1:0];
  endfunction

  function automatic addr_t caddr_of(input child_t pos);
    child_t dec;
    dec = pos - child_t'(1);
    return dec[ADDR_W-1:0];
  endfunction

  bhpq_key_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bhpq_rank_unit u_rank (
    .max_order (max_order_r),
    .upper     (cmp_upper),
    .lower     (cmp_lower),
    .outranked (outr)
  );

  // Order register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_order_r <= 1'b1;
    end else if (cfg_we) begin
      max_order_r <= cfg_wdata;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload.
  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    cur_r       <= cur_nxt;
    pick_key_r  <= pick_key_nxt;
    pick_left_r <= pick_left_nxt;
    removed_r   <= removed_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Next state, RAM accesses and result.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    p_nxt         = p_r;
    cur_nxt       = cur_r;
    pick_key_nxt  = pick_key_r;
    pick_left_nxt = pick_left_r;
    removed_nxt   = removed_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    ram_we    = 1'b0;
    ram_waddr = addr_of(p_r);
    ram_wdata = cur_r;
    ram_raddr = '0;
    cmp_upper = cur_r;
    cmp_lower = ram_rdata;

    fin_en      = 1'b0;
    fin_status  = ST_OK;
    fin_removed = removed_r;
    desc_en     = 1'b0;
    desc_pos    = p_r;
    desc_key    = cur_r;

    ins_pos   = count_r + pos_t'(1);
    par_pos   = p_r >> 1;
    left_pos  = {p_r, 1'b0};
    right_pos = {p_r, 1'b1};
    count_ext = {1'b0, count_r};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cur_nxt     = in_data.item_value;
          removed_nxt = '0;
          fin_removed = '0;
          case (in_data.kind)
            KIND_INSERT: begin
              if (count_r == pos_t'(CAPACITY)) begin
                fin_en     = 1'b1;
                fin_status = ST_FULL;
              end else begin
                count_nxt = ins_pos;
                p_nxt     = ins_pos;
                if (count_r == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = in_data.item_value;
                  fin_en    = 1'b1;
                end else begin
                  ram_raddr = addr_of(ins_pos >> 1);
                  state_nxt = S_UP;
                end
              end
            end
            KIND_REMOVE: begin
              if (count_r == '0) begin
                fin_en     = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                ram_raddr = '0;
                state_nxt = S_RM_ROOT;
              end
            end
            KIND_CHANGE: begin
              if (in_data.position == '0 || in_data.position > count_r) begin
                fin_en     = 1'b1;
                fin_status = ST_RANGE;
              end else begin
                p_nxt     = in_data.position;
                ram_raddr = addr_of(in_data.position);
                state_nxt = S_CHG;
              end
            end
            default: begin
              count_nxt = '0;
              fin_en    = 1'b1;
            end
          endcase
        end
      end

      // Root arrives; fetch the last key and shrink the heap.
      S_RM_ROOT: begin
        removed_nxt = ram_rdata;
        ram_raddr   = addr_of(count_r);
        count_nxt   = count_r - pos_t'(1);
        p_nxt       = pos_t'(1);
        state_nxt   = S_RM_LAST;
      end

      // Last key arrives and starts sinking from the root.
      S_RM_LAST: begin
        cur_nxt = ram_rdata;
        if (left_pos <= count_ext) begin
          ram_raddr = caddr_of(left_pos);
          state_nxt = S_DN_L;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          fin_en    = 1'b1;
        end
      end

      // Old key arrives; the new key rises if it outranks the old one, else it sinks.
      S_CHG: begin
        cmp_upper = ram_rdata;
        cmp_lower = cur_r;
        if (outr) begin
          if (p_r == pos_t'(1)) begin
            ram_we = 1'b1;
            fin_en = 1'b1;
          end else begin
            ram_raddr = addr_of(par_pos);
            state_nxt = S_UP;
          end
        end else if (left_pos <= count_ext) begin
          ram_raddr = caddr_of(left_pos);
          state_nxt = S_DN_L;
        end else begin
          ram_we = 1'b1;
          fin_en = 1'b1;
        end
      end

      // Parent key arrives; move it down while it ranks below the moving key.
      S_UP: begin
        cmp_upper = ram_rdata;
        cmp_lower = cur_r;
        if (outr) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          p_nxt     = par_pos;
          if (par_pos == pos_t'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            ram_raddr = addr_of(par_pos >> 1);
          end
        end else begin
          ram_we = 1'b1;
          fin_en = 1'b1;
        end
      end

      // Left child arrives; compare against the moving key.
      S_DN_L: begin
        cmp_upper     = cur_r;
        cmp_lower     = ram_rdata;
        pick_left_nxt = outr;
        pick_key_nxt  = outr ? ram_rdata : cur_r;
        if (right_pos <= count_ext) begin
          ram_raddr = caddr_of(right_pos);
          state_nxt = S_DN_R;
        end else if (outr) begin
          desc_en  = 1'b1;
          desc_pos = left_pos[POS_W-1:0];
          desc_key = ram_rdata;
        end else begin
          ram_we = 1'b1;
          fin_en = 1'b1;
        end
      end

      // Right child arrives; it wins only if it beats the current pick.
      S_DN_R: begin
        cmp_upper = pick_key_r;
        cmp_lower = ram_rdata;
        if (outr) begin
          desc_en  = 1'b1;
          desc_pos = right_pos[POS_W-1:0];
          desc_key = ram_rdata;
        end else if (pick_left_r) begin
          desc_en  = 1'b1;
          desc_pos = left_pos[POS_W-1:0];
          desc_key = pick_key_r;
        end else begin
          ram_we = 1'b1;
          fin_en = 1'b1;
        end
      end

      // Drop the moving key into its final slot.
      S_PLACE: begin
        ram_we = 1'b1;
        fin_en = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // One level of sift down: lift the child key and follow it.
    if (desc_en) begin
      ram_we    = 1'b1;
      ram_waddr = addr_of(p_r);
      ram_wdata = desc_key;
      p_nxt     = desc_pos;
      if ({desc_pos, 1'b0} <= count_ext) begin
        ram_raddr = caddr_of({desc_pos, 1'b0});
        state_nxt = S_DN_L;
      end else begin
        state_nxt = S_PLACE;
      end
    end

    // Close the beat and load the result register.
    if (fin_en) begin
      state_nxt                  = S_IDLE;
      out_valid_nxt              = 1'b1;
      out_data_nxt.removed_value = fin_removed;
      out_data_nxt.status        = fin_status;
      out_data_nxt.entry_total   = count_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
